// ===== design/mtl_pkg.sv =====
// Shared constants, character codes, token codes and queue status type for the tag lexer.
package mtl_pkg;

   localparam int unsigned DEF_OFFSET_BITS   = 24;
   localparam int unsigned DEF_LINE_COL_BITS = 16;
   localparam int unsigned QUEUE_DEPTH       = 4;
   localparam int unsigned TYPE_BITS         = 4;
   localparam int unsigned RUN_SLOTS         = 3;

   localparam logic [TYPE_BITS-1:0] TK_LT       = 4'd0;
   localparam logic [TYPE_BITS-1:0] TK_LT_SLASH = 4'd1;
   localparam logic [TYPE_BITS-1:0] TK_GT       = 4'd2;
   localparam logic [TYPE_BITS-1:0] TK_SLASH_GT = 4'd3;
   localparam logic [TYPE_BITS-1:0] TK_EQUALS   = 4'd4;
   localparam logic [TYPE_BITS-1:0] TK_STRING   = 4'd5;
   localparam logic [TYPE_BITS-1:0] TK_NUMBER   = 4'd6;
   localparam logic [TYPE_BITS-1:0] TK_IDENT    = 4'd7;
   localparam logic [TYPE_BITS-1:0] TK_EOF      = 4'd8;

   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   typedef struct packed {
      logic full;
      logic empty;
   } mtlq_status_type;

endpackage

// ===== design/mtl_channels.sv =====
// Request and response channel interfaces of the tag lexer.
interface mtl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       final_byte;

   modport source (output valid, output ch, output final_byte, input ready);
   modport sink   (input valid, input ch, input final_byte, output ready);
endinterface

interface mtl_rsp_if
   import mtl_pkg::*;
#(
   parameter int unsigned LINE_COL_BITS = DEF_LINE_COL_BITS,
   parameter int unsigned OFFSET_BITS   = DEF_OFFSET_BITS
);
   logic                     valid;
   logic                     ready;
   logic [TYPE_BITS-1:0]     token_type;
   logic [LINE_COL_BITS-1:0] line_number;
   logic [LINE_COL_BITS-1:0] column_number;
   logic [OFFSET_BITS-1:0]   text_offset;
   logic [OFFSET_BITS-1:0]   text_length;
   logic                     last_of_run;

   modport source (output valid, output token_type, output line_number, output column_number,
                   output text_offset, output text_length, output last_of_run, input ready);
   modport sink   (input valid, input token_type, input line_number, input column_number,
                   input text_offset, input text_length, input last_of_run, output ready);
endinterface

// ===== design/markup_tag_lexer_unit.sv =====
// Tokens of a request pass through the queue, run register and output register to rsp_if.
// One request per cycle while the queue is not full; the response side delivers one token
// per cycle while rsp_if is ready, and a four-run queue absorbs bursts.
// Requests that yield no token never enter the queue.
// Reset (synchronous, active high) returns the scanner to line 1, column 1, offset 0 and
// empties the queue and the output register; no clearing pass is needed.
module markup_tag_lexer_unit
   import mtl_pkg::*;
#(
   parameter int unsigned LINE_COL_BITS = DEF_LINE_COL_BITS,
   parameter int unsigned OFFSET_BITS   = DEF_OFFSET_BITS
) (
   input  logic       clock,
   input  logic       reset,
   mtl_req_if.sink    req_if,
   mtl_rsp_if.source  rsp_if
);

   localparam int unsigned TOK_W = TYPE_BITS + 2 * LINE_COL_BITS + 2 * OFFSET_BITS;
   localparam int unsigned RUN_W = RUN_SLOTS + RUN_SLOTS * TOK_W;

   mtlq_status_type  q_status;
   logic             push, pop;
   logic [RUN_W-1:0] push_data, head_data;
   logic [TOK_W-1:0] out_token;

   mtl_front #(
      .LINE_COL_BITS (LINE_COL_BITS),
      .OFFSET_BITS   (OFFSET_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_if.valid),
      .in_ch    (req_if.ch),
      .in_final (req_if.final_byte),
      .in_ready (req_if.ready),
      .q_status (q_status),
      .push     (push),
      .run_data (push_data)
   );

   mtl_queue #(
      .LINE_COL_BITS (LINE_COL_BITS),
      .OFFSET_BITS   (OFFSET_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (q_status)
   );

   mtl_back #(
      .LINE_COL_BITS (LINE_COL_BITS),
      .OFFSET_BITS   (OFFSET_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .q_status  (q_status),
      .pop       (pop),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_token (out_token),
      .out_last  (rsp_if.last_of_run)
   );

   assign {rsp_if.token_type, rsp_if.line_number, rsp_if.column_number,
           rsp_if.text_offset, rsp_if.text_length} = out_token;

endmodule

// ===== design/mtl_front.sv =====
// Front end: classifies each byte, updates the scanner state and builds the run of tokens.
module mtl_front
   import mtl_pkg::*;
#(
   parameter int unsigned LINE_COL_BITS = DEF_LINE_COL_BITS,
   parameter int unsigned OFFSET_BITS   = DEF_OFFSET_BITS,
   localparam int unsigned TOK_W = TYPE_BITS + 2 * LINE_COL_BITS + 2 * OFFSET_BITS,
   localparam int unsigned RUN_W = RUN_SLOTS + RUN_SLOTS * TOK_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [7:0]           in_ch,
   input  logic                 in_final,
   output logic                 in_ready,
   input  mtlq_status_type      q_status,
   output logic                 push,
   output logic [RUN_W-1:0]     run_data
);

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_LT     = 3'd1;
   localparam logic [2:0] MODE_SLASH  = 3'd2;
   localparam logic [2:0] MODE_MINUS  = 3'd3;
   localparam logic [2:0] MODE_STRING = 3'd4;
   localparam logic [2:0] MODE_NUMBER = 3'd5;
   localparam logic [2:0] MODE_IDENT  = 3'd6;

   localparam int unsigned LCB = LINE_COL_BITS;
   localparam int unsigned OB  = OFFSET_BITS;

   logic [2:0]     mode_ff, mode_in;
   logic           qs_ff, qs_in;
   logic           dp_ff, dp_in;
   logic [LCB-1:0] line_ff, line_in;
   logic [LCB-1:0] col_ff, col_in;
   logic [OB-1:0]  pos_ff, pos_in;
   logic [LCB-1:0] tcol_ff, tcol_in;
   logic [OB-1:0]  toff_ff, toff_in;
   logic [OB-1:0]  tlen_ff, tlen_in;

   logic accept;
   logic is_digit, is_alpha, is_space, is_nl, is_lt, is_gt, is_slash, is_eq;
   logic is_dq, is_sq, is_minus, is_dot, ident_start, ident_more, close_q;

   logic [2:0]           mode_mid;
   logic                 qs_mid, dp_mid;
   logic [LCB-1:0]       tcol_mid;
   logic [OB-1:0]        toff_mid, tlen_mid;
   logic                 fresh;
   logic                 held_v;
   logic [TYPE_BITS-1:0] held_type;
   logic [OB-1:0]        held_len;
   logic                 mid_v;
   logic [TYPE_BITS-1:0] mid_type;
   logic [TOK_W-1:0]     mid_tok;
   logic                 fin_held;
   logic [TYPE_BITS-1:0] fin_type;
   logic [OB-1:0]        tlen_inc, pos_inc;
   logic [LCB-1:0]       col_inc, line_inc;
   logic [LCB-1:0]       line_new, col_new;
   logic [OB-1:0]        pos_new;
   logic [TOK_W-1:0]     tok_a, tok_m, tok_e;
   logic [RUN_SLOTS-1:0] mask;

   assign in_ready = !q_status.full;
   assign accept   = in_valid && in_ready;

   assign is_digit   = (in_ch >= 8'h30) && (in_ch <= 8'h39);
   assign is_alpha   = ((in_ch >= 8'h61) && (in_ch <= 8'h7A)) ||
                       ((in_ch >= 8'h41) && (in_ch <= 8'h5A));
   assign is_space   = (in_ch == CH_SPACE) || ((in_ch >= CH_TAB) && (in_ch <= CH_CR));
   assign is_nl      = (in_ch == CH_NEWLINE);
   assign is_lt      = (in_ch == CH_LT);
   assign is_gt      = (in_ch == CH_GT);
   assign is_slash   = (in_ch == CH_SLASH);
   assign is_eq      = (in_ch == CH_EQUALS);
   assign is_dq      = (in_ch == CH_DQUOTE);
   assign is_sq      = (in_ch == CH_SQUOTE);
   assign is_minus   = (in_ch == CH_MINUS);
   assign is_dot     = (in_ch == CH_DOT);
   assign ident_start = is_alpha || (in_ch == CH_UNDER) || (in_ch == CH_COLON);
   assign ident_more  = ident_start || is_digit || is_minus;
   assign close_q     = qs_ff ? is_sq : is_dq;

   assign tlen_inc = (tlen_ff == '1) ? tlen_ff : tlen_ff + OB'(1);
   assign pos_inc  = (pos_ff == '1) ? pos_ff : pos_ff + OB'(1);
   assign col_inc  = (col_ff == '1) ? col_ff : col_ff + LCB'(1);
   assign line_inc = (line_ff == '1) ? line_ff : line_ff + LCB'(1);
   assign line_new = is_nl ? line_inc : line_ff;
   assign col_new  = is_nl ? LCB'(1) : col_inc;
   assign pos_new  = pos_inc;

   always_comb begin
      mode_mid  = mode_ff;
      qs_mid    = qs_ff;
      dp_mid    = dp_ff;
      tcol_mid  = tcol_ff;
      toff_mid  = toff_ff;
      tlen_mid  = tlen_ff;
      fresh     = 1'b0;
      held_v    = 1'b0;
      held_type = TK_LT;
      held_len  = tlen_ff;
      mid_v     = 1'b0;
      mid_type  = TK_GT;

      unique case (mode_ff)
         MODE_STRING: begin
            if (close_q) begin
               held_v    = 1'b1;
               held_type = TK_STRING;
               mode_mid  = MODE_IDLE;
            end else begin
               tlen_mid = tlen_inc;
            end
         end
         MODE_NUMBER: begin
            if (is_digit) begin
               tlen_mid = tlen_inc;
            end else if (is_dot && !dp_ff) begin
               dp_mid   = 1'b1;
               tlen_mid = tlen_inc;
            end else begin
               held_v    = 1'b1;
               held_type = TK_NUMBER;
               fresh     = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (ident_more) begin
               tlen_mid = tlen_inc;
            end else begin
               held_v    = 1'b1;
               held_type = TK_IDENT;
               fresh     = 1'b1;
            end
         end
         MODE_LT: begin
            held_v = 1'b1;
            if (is_slash) begin
               held_type = TK_LT_SLASH;
               held_len  = OB'(2);
               tlen_mid  = OB'(2);
               mode_mid  = MODE_IDLE;
            end else begin
               held_type = TK_LT;
               fresh     = 1'b1;
            end
         end
         MODE_SLASH: begin
            if (is_gt) begin
               held_v    = 1'b1;
               held_type = TK_SLASH_GT;
               held_len  = OB'(2);
               tlen_mid  = OB'(2);
               mode_mid  = MODE_IDLE;
            end else begin
               fresh = 1'b1;
            end
         end
         MODE_MINUS: begin
            if (is_digit) begin
               mode_mid = MODE_NUMBER;
               dp_mid   = 1'b0;
               tlen_mid = OB'(2);
            end else begin
               fresh = 1'b1;
            end
         end
         default: begin
            fresh = 1'b1;
         end
      endcase

      // Whitespace and unknown bytes fall through every branch and leave the scanner idle.
      if (fresh) begin
         mode_mid = MODE_IDLE;
         if (is_space) begin
            mode_mid = MODE_IDLE;
         end else if (is_lt) begin
            mode_mid = MODE_LT;
            tcol_mid = col_ff;
            toff_mid = pos_ff;
            tlen_mid = OB'(1);
         end else if (is_gt) begin
            mid_v    = 1'b1;
            mid_type = TK_GT;
         end else if (is_slash) begin
            mode_mid = MODE_SLASH;
            tcol_mid = col_ff;
            toff_mid = pos_ff;
            tlen_mid = OB'(1);
         end else if (is_eq) begin
            mid_v    = 1'b1;
            mid_type = TK_EQUALS;
         end else if (is_dq || is_sq) begin
            qs_mid   = is_sq;
            mode_mid = MODE_STRING;
            tcol_mid = col_ff;
            toff_mid = pos_inc;
            tlen_mid = '0;
         end else if (is_digit) begin
            dp_mid   = 1'b0;
            mode_mid = MODE_NUMBER;
            tcol_mid = col_ff;
            toff_mid = pos_ff;
            tlen_mid = OB'(1);
         end else if (is_minus) begin
            mode_mid = MODE_MINUS;
            tcol_mid = col_ff;
            toff_mid = pos_ff;
            tlen_mid = OB'(1);
         end else if (ident_start) begin
            mode_mid = MODE_IDENT;
            tcol_mid = col_ff;
            toff_mid = pos_ff;
            tlen_mid = OB'(1);
         end
      end
   end

   always_comb begin
      fin_held = 1'b0;
      fin_type = TK_LT;
      if (in_final) begin
         unique case (mode_mid)
            MODE_STRING: begin
               fin_held = 1'b1;
               fin_type = TK_STRING;
            end
            MODE_NUMBER: begin
               fin_held = 1'b1;
               fin_type = TK_NUMBER;
            end
            MODE_IDENT: begin
               fin_held = 1'b1;
               fin_type = TK_IDENT;
            end
            MODE_LT: begin
               fin_held = 1'b1;
               fin_type = TK_LT;
            end
            default: begin
               fin_held = 1'b0;
            end
         endcase
      end
   end

   // A gt or equals token leaves the scanner idle, so it never shares the middle slot
   // with a token flushed at the end of the source.
   always_comb begin
      if (fin_held) begin
         mid_tok = {fin_type, line_new, tcol_mid, toff_mid, tlen_mid};
      end else begin
         mid_tok = {mid_type, line_ff, col_ff, pos_ff, OB'(1)};
      end
   end

   assign tok_a = {held_type, line_ff, tcol_ff, toff_ff, held_len};
   assign tok_m = mid_tok;
   assign tok_e = {TK_EOF, line_new, col_new, pos_new, OB'(0)};
   assign mask  = {in_final, mid_v || fin_held, held_v};

   assign run_data = {mask, tok_e, tok_m, tok_a};
   assign push     = accept && (mask != '0);

   always_comb begin
      mode_in = mode_ff;
      qs_in   = qs_ff;
      dp_in   = dp_ff;
      line_in = line_ff;
      col_in  = col_ff;
      pos_in  = pos_ff;
      tcol_in = tcol_ff;
      toff_in = toff_ff;
      tlen_in = tlen_ff;
      if (accept) begin
         if (in_final) begin
            mode_in = MODE_IDLE;
            qs_in   = 1'b0;
            dp_in   = 1'b0;
            line_in = LCB'(1);
            col_in  = LCB'(1);
            pos_in  = '0;
            tcol_in = LCB'(1);
            toff_in = '0;
            tlen_in = '0;
         end else begin
            mode_in = mode_mid;
            qs_in   = qs_mid;
            dp_in   = dp_mid;
            line_in = line_new;
            col_in  = col_new;
            pos_in  = pos_new;
            tcol_in = tcol_mid;
            toff_in = toff_mid;
            tlen_in = tlen_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         qs_ff   <= 1'b0;
         dp_ff   <= 1'b0;
         line_ff <= LCB'(1);
         col_ff  <= LCB'(1);
         pos_ff  <= '0;
         tcol_ff <= LCB'(1);
         toff_ff <= '0;
         tlen_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         qs_ff   <= qs_in;
         dp_ff   <= dp_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         pos_ff  <= pos_in;
         tcol_ff <= tcol_in;
         toff_ff <= toff_in;
         tlen_ff <= tlen_in;
      end
   end

`ifndef ASSERT_OFF
   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && in_final |=> (mode_ff == MODE_IDLE) && (pos_ff == '0) && (line_ff == LCB'(1)))
      else $error("scanner state not restarted after the last byte of a source");

   a_line_col_nonzero: assert property (@(posedge clock) disable iff (reset)
      (line_ff != '0) && (col_ff != '0))
      else $error("line or column counter reached zero");
`endif

endmodule

// ===== design/mtl_queue.sv =====
// Small queue of token runs between the front end and the output side.
module mtl_queue
   import mtl_pkg::*;
#(
   parameter int unsigned LINE_COL_BITS = DEF_LINE_COL_BITS,
   parameter int unsigned OFFSET_BITS   = DEF_OFFSET_BITS,
   localparam int unsigned TOK_W = TYPE_BITS + 2 * LINE_COL_BITS + 2 * OFFSET_BITS,
   localparam int unsigned RUN_W = RUN_SLOTS + RUN_SLOTS * TOK_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [RUN_W-1:0] push_data,
   input  logic             pop,
   output logic [RUN_W-1:0] head_data,
   output mtlq_status_type  status
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   logic [RUN_W-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_data    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count beyond its depth");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("run pushed into a full queue");
`endif

endmodule

// ===== design/mtl_back.sv =====
// Output side: unpacks queued runs and hands out their tokens one per cycle unless stalled.
module mtl_back
   import mtl_pkg::*;
#(
   parameter int unsigned LINE_COL_BITS = DEF_LINE_COL_BITS,
   parameter int unsigned OFFSET_BITS   = DEF_OFFSET_BITS,
   localparam int unsigned TOK_W = TYPE_BITS + 2 * LINE_COL_BITS + 2 * OFFSET_BITS,
   localparam int unsigned RUN_W = RUN_SLOTS + RUN_SLOTS * TOK_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [RUN_W-1:0] head_data,
   input  mtlq_status_type  q_status,
   output logic             pop,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [TOK_W-1:0] out_token,
   output logic             out_last
);

   logic [RUN_SLOTS*TOK_W-1:0] run_ff, run_in;
   logic [RUN_SLOTS-1:0]       rem_ff, rem_in;
   logic                       valid_ff, valid_in;
   logic [TOK_W-1:0]           tok_ff, tok_in;
   logic                       last_ff, last_in;

   logic                       out_free, emit;
   logic [RUN_SLOTS-1:0]       pick, rem_next;
   logic [TOK_W-1:0]           pick_tok;
   logic [RUN_SLOTS-1:0]       head_mask;

   assign head_mask = head_data[RUN_W-1 -: RUN_SLOTS];
   assign out_free  = !valid_ff || out_ready;
   assign emit      = out_free && (rem_ff != '0);
   assign pick      = rem_ff & (~rem_ff + RUN_SLOTS'(1));
   assign rem_next  = rem_ff & ~pick;
   assign pop       = ((rem_ff == '0) || (emit && (rem_next == '0))) && !q_status.empty;

   always_comb begin
      pick_tok = '0;
      for (int i = 0; i < RUN_SLOTS; i++) begin
         if (pick[i]) begin
            pick_tok = run_ff[i*TOK_W +: TOK_W];
         end
      end
   end

   always_comb begin
      run_in   = run_ff;
      rem_in   = rem_ff;
      valid_in = valid_ff;
      tok_in   = tok_ff;
      last_in  = last_ff;
      if (emit) begin
         rem_in = rem_next;
      end
      if (pop) begin
         run_in = head_data[RUN_SLOTS*TOK_W-1:0];
         rem_in = head_mask;
      end
      if (emit) begin
         valid_in = 1'b1;
         tok_in   = pick_tok;
         last_in  = (rem_next == '0);
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      run_ff  <= run_in;
      tok_ff  <= tok_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         rem_ff   <= rem_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_token = tok_ff;
   assign out_last  = last_ff;

`ifndef ASSERT_OFF
   a_pop_has_tokens: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head_mask != '0))
      else $error("queue handed over a run without tokens");
`endif

endmodule
